// File: rtl/gcipsd_pkg.sv
package gcipsd_pkg;

	// Fixed field widths
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned STAMP_W    = 64;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned BASE_W     = 22;
	localparam int unsigned CHARGE_W   = 35;
	localparam int unsigned COUNT_W    = 12;
	localparam int unsigned START_W    = 16;
	localparam int unsigned INDEX_W    = 17;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned FRAC_W     = 6;

	// Stream payload widths, padded to whole bytes
	localparam int unsigned IN_TDATA_W  = 88;
	localparam int unsigned OUT_TDATA_W = 168;

	localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

	// Register reset values
	localparam logic [START_W-1:0] START_RESET      = 16'd110;
	localparam logic [COUNT_W-1:0] GATE_SHORT_RESET = 12'd30;
	localparam logic [COUNT_W-1:0] GATE_LONG_RESET  = 12'd90;

	// Configuration register indices
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTEGRATION_START = 2'd0,
		REG_GATE_SHORT        = 2'd1,
		REG_GATE_LONG         = 2'd2,
		REG_POSITIVE_PULSE    = 2'd3
	} cfg_reg_t;

endpackage

// File: rtl/gcipsd_charge_pipe.sv
module gcipsd_charge_pipe #(
	parameter int unsigned BASELINE_COUNT = 64,
	parameter int unsigned SAMPLE_BITS    = 16
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    in_valid,
	output logic                                                    in_ready,
	input  logic [gcipsd_pkg::STAMP_W-1:0]                          in_stamp,
	input  logic [gcipsd_pkg::CHAN_W-1:0]                           in_channel,
	input  logic                                                    in_pol,
	input  logic [SAMPLE_BITS+$clog2(BASELINE_COUNT)-1:0]           in_bsum,
	input  logic [SAMPLE_BITS+gcipsd_pkg::COUNT_W-1:0]              in_ssum,
	input  logic [gcipsd_pkg::COUNT_W-1:0]                          in_scnt,
	input  logic [SAMPLE_BITS+gcipsd_pkg::COUNT_W-1:0]              in_lsum,
	input  logic [gcipsd_pkg::COUNT_W-1:0]                          in_lcnt,
	output logic                                                    out_valid,
	input  logic                                                    out_ready,
	output logic [gcipsd_pkg::STAMP_W-1:0]                          out_stamp,
	output logic [gcipsd_pkg::CHAN_W-1:0]                           out_channel,
	output logic [gcipsd_pkg::BASE_W-1:0]                           out_base,
	output logic signed [gcipsd_pkg::CHARGE_W-1:0]                  out_short,
	output logic signed [gcipsd_pkg::CHARGE_W-1:0]                  out_long
);

	localparam int unsigned SUMW  = SAMPLE_BITS + $clog2(BASELINE_COUNT);
	localparam int unsigned XW    = SUMW + gcipsd_pkg::FRAC_W;
	localparam int unsigned QW    = SAMPLE_BITS + gcipsd_pkg::FRAC_W;
	localparam int unsigned GSUMW = SAMPLE_BITS + gcipsd_pkg::COUNT_W;
	localparam int unsigned PW    = gcipsd_pkg::COUNT_W + QW;
	localparam int unsigned BCW   = $clog2(BASELINE_COUNT) + 1;
	localparam logic [2*XW-1:0] ONE_K = (2*XW)'(1) << XW;
	localparam logic [XW-1:0]   RECIP = XW'(ONE_K / BASELINE_COUNT);
	localparam logic [BCW-1:0]  BC_L  = BCW'(BASELINE_COUNT);

	// Stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_out;

	// Payload that rides along every stage
	logic [gcipsd_pkg::STAMP_W-1:0] stamp_s1, stamp_s2, stamp_s3, stamp_s4, stamp_s5;
	logic [gcipsd_pkg::CHAN_W-1:0]  chan_s1, chan_s2, chan_s3, chan_s4, chan_s5;
	logic                           pol_s1, pol_s2, pol_s3, pol_s4, pol_s5;
	logic [GSUMW-1:0]               ssum_s1, ssum_s2, ssum_s3, ssum_s4;
	logic [GSUMW-1:0]               lsum_s1, lsum_s2, lsum_s3, lsum_s4;
	logic [gcipsd_pkg::COUNT_W-1:0] scnt_s1, scnt_s2, scnt_s3, scnt_s4;
	logic [gcipsd_pkg::COUNT_W-1:0] lcnt_s1, lcnt_s2, lcnt_s3, lcnt_s4;

	// Baseline division path
	logic [SUMW-1:0]   bsum_s1, bsum_s2;
	logic [2*XW-1:0]   prod_s2;
	logic [QW-1:0]     q0_s3;
	logic [BCW-1:0]    rem_s3;
	logic [QW-1:0]     base_s4, base_s5;

	// Charge path
	logic [PW-1:0]     sprod_s5, lprod_s5, sref_s5, lref_s5;

	// Output register
	logic [gcipsd_pkg::STAMP_W-1:0]        stamp_q;
	logic [gcipsd_pkg::CHAN_W-1:0]         chan_q;
	logic [gcipsd_pkg::BASE_W-1:0]         base_q;
	logic signed [gcipsd_pkg::CHARGE_W-1:0] short_q, long_q;

	logic [XW-1:0]     x_s1, x_s2, qbc_s2;
	logic [QW-1:0]     q0_s2;
	logic signed [PW:0] sdiff, ldiff;
	logic signed [gcipsd_pkg::CHARGE_W-1:0] sext, lext;

	// Advance a stage when it is empty or the next one moves
	assign en_out   = !out_valid_q || out_ready;
	assign en_s5    = !v_s5 || en_out;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1        <= in_valid;
			if (en_s2)  v_s2        <= v_s1;
			if (en_s3)  v_s3        <= v_s2;
			if (en_s4)  v_s4        <= v_s3;
			if (en_s5)  v_s5        <= v_s4;
			if (en_out) out_valid_q <= v_s5;
		end
	end

	// Stage 1: capture the finished waveform's totals
	always_ff @(posedge clk) begin
		if (en_s1) begin
			stamp_s1 <= in_stamp;
			chan_s1  <= in_channel;
			pol_s1   <= in_pol;
			bsum_s1  <= in_bsum;
			ssum_s1  <= in_ssum;
			scnt_s1  <= in_scnt;
			lsum_s1  <= in_lsum;
			lcnt_s1  <= in_lcnt;
		end
	end

	// Stage 2: multiply the scaled baseline sum by the reciprocal of the count
	assign x_s1 = {bsum_s1, gcipsd_pkg::FRAC_W'(0)};

	always_ff @(posedge clk) begin
		if (en_s2) begin
			stamp_s2 <= stamp_s1;
			chan_s2  <= chan_s1;
			pol_s2   <= pol_s1;
			bsum_s2  <= bsum_s1;
			ssum_s2  <= ssum_s1;
			scnt_s2  <= scnt_s1;
			lsum_s2  <= lsum_s1;
			lcnt_s2  <= lcnt_s1;
			prod_s2  <= (2*XW)'(x_s1) * (2*XW)'(RECIP);
		end
	end

	// Stage 3: estimate the quotient (low by at most one) and its remainder
	assign x_s2   = {bsum_s2, gcipsd_pkg::FRAC_W'(0)};
	assign q0_s2  = prod_s2[XW +: QW];
	assign qbc_s2 = XW'(XW'(q0_s2) * XW'(BASELINE_COUNT));

	always_ff @(posedge clk) begin
		if (en_s3) begin
			stamp_s3 <= stamp_s2;
			chan_s3  <= chan_s2;
			pol_s3   <= pol_s2;
			ssum_s3  <= ssum_s2;
			scnt_s3  <= scnt_s2;
			lsum_s3  <= lsum_s2;
			lcnt_s3  <= lcnt_s2;
			q0_s3    <= q0_s2;
			rem_s3   <= BCW'(x_s2 - qbc_s2);
		end
	end

	// Stage 4: correct the quotient to give the truncated baseline
	always_ff @(posedge clk) begin
		if (en_s4) begin
			stamp_s4 <= stamp_s3;
			chan_s4  <= chan_s3;
			pol_s4   <= pol_s3;
			ssum_s4  <= ssum_s3;
			scnt_s4  <= scnt_s3;
			lsum_s4  <= lsum_s3;
			lcnt_s4  <= lcnt_s3;
			base_s4  <= q0_s3 + QW'(rem_s3 >= BC_L);
		end
	end

	// Stage 5: scale the baseline by each gate count
	always_ff @(posedge clk) begin
		if (en_s5) begin
			stamp_s5 <= stamp_s4;
			chan_s5  <= chan_s4;
			pol_s5   <= pol_s4;
			base_s5  <= base_s4;
			sprod_s5 <= PW'(scnt_s4) * PW'(base_s4);
			lprod_s5 <= PW'(lcnt_s4) * PW'(base_s4);
			sref_s5  <= {ssum_s4, gcipsd_pkg::FRAC_W'(0)};
			lref_s5  <= {lsum_s4, gcipsd_pkg::FRAC_W'(0)};
		end
	end

	// Subtract the gated sums and apply the pulse polarity
	assign sdiff = $signed({1'b0, sprod_s5}) - $signed({1'b0, sref_s5});
	assign ldiff = $signed({1'b0, lprod_s5}) - $signed({1'b0, lref_s5});
	assign sext  = gcipsd_pkg::CHARGE_W'(sdiff);
	assign lext  = gcipsd_pkg::CHARGE_W'(ldiff);

	always_ff @(posedge clk) begin
		if (en_out) begin
			stamp_q <= stamp_s5;
			chan_q  <= chan_s5;
			base_q  <= gcipsd_pkg::BASE_W'(base_s5);
			short_q <= pol_s5 ? -sext : sext;
			long_q  <= pol_s5 ? -lext : lext;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_stamp   = stamp_q;
	assign out_channel = chan_q;
	assign out_base    = base_q;
	assign out_short   = short_q;
	assign out_long    = long_q;

endmodule

// File: rtl/gated_charge_integrator_psd.sv
// Gated charge integrator for pulse shape discrimination.
// Input stream: one digitizer sample per request, tlast on the final sample
// of a waveform. tdata carries the sample, the timestamp and the channel;
// timestamp and channel are taken from the first sample of each waveform.
// Output stream: one request per waveform, issued for the tlast sample,
// carrying timestamp, channel, baseline (six fraction bits) and the short
// and long gate charges (signed, six fraction bits).
// Throughput: one sample per cycle while s_tready is high. Each sample only
// updates the running sums and counters; the per-waveform division and charge
// arithmetic runs in a six-register result pipeline behind it.
// m_tvalid rises once the waveform's totals have reached its output register.
// When the receiver stalls, the result pipeline fills and s_tready drops
// only once its entry stage is occupied and blocked; no result is lost.
// Configuration writes take effect at the next sample and should be made
// between waveforms. Reset clears the accumulators, returns the registers
// to their defaults and empties the result pipeline.
module gated_charge_integrator_psd_core #(
	parameter int unsigned BASELINE_COUNT = 64,
	parameter int unsigned SAMPLE_BITS    = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// sample[15:0], stamp_in[79:16], channel_in[87:80]
	input  logic [gcipsd_pkg::IN_TDATA_W-1:0]        s_tdata,
	input  logic                                     s_tlast,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// stamp_out[63:0], channel_out[71:64], baseline_fixed[93:72],
	// charge_short[128:94], charge_long[163:129], zero [167:164]
	output logic [gcipsd_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	input  logic                                     cfg_we,
	input  logic [gcipsd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [gcipsd_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int unsigned SUMW  = SAMPLE_BITS + $clog2(BASELINE_COUNT);
	localparam int unsigned GSUMW = SAMPLE_BITS + gcipsd_pkg::COUNT_W;
	localparam logic [gcipsd_pkg::INDEX_W-1:0] BASE_END =
		gcipsd_pkg::INDEX_W'(BASELINE_COUNT);

	// Configuration registers
	logic [gcipsd_pkg::START_W-1:0] start_q;
	logic [gcipsd_pkg::COUNT_W-1:0] gate_short_q, gate_long_q;
	logic                           pol_q;

	// Waveform state
	logic [gcipsd_pkg::INDEX_W-1:0] idx_q;
	logic [SUMW-1:0]                bsum_q;
	logic [GSUMW-1:0]               ssum_q, lsum_q;
	logic [gcipsd_pkg::COUNT_W-1:0] scnt_q, lcnt_q;
	logic [gcipsd_pkg::STAMP_W-1:0] stamp_q;
	logic [gcipsd_pkg::CHAN_W-1:0]  chan_q;

	// Next-state values including the current sample
	logic [SAMPLE_BITS-1:0]         smp;
	logic [gcipsd_pkg::STAMP_W-1:0] stamp_in;
	logic [gcipsd_pkg::CHAN_W-1:0]  chan_in;
	logic [gcipsd_pkg::INDEX_W-1:0] gate_begin, short_end, long_end;
	logic                           first, in_base, in_short, in_long, take;
	logic [SUMW-1:0]                bsum_nx;
	logic [GSUMW-1:0]               ssum_nx, lsum_nx;
	logic [gcipsd_pkg::COUNT_W-1:0] scnt_nx, lcnt_nx;
	logic [gcipsd_pkg::STAMP_W-1:0] stamp_nx;
	logic [gcipsd_pkg::CHAN_W-1:0]  chan_nx;
	logic                           res_ready;

	// Result fields
	logic [gcipsd_pkg::STAMP_W-1:0]         stamp_out;
	logic [gcipsd_pkg::CHAN_W-1:0]          channel_out;
	logic [gcipsd_pkg::BASE_W-1:0]          baseline_fixed;
	logic signed [gcipsd_pkg::CHARGE_W-1:0] charge_short, charge_long;

	// Unpack the sample request
	assign smp      = s_tdata[SAMPLE_BITS-1:0];
	assign stamp_in = s_tdata[gcipsd_pkg::SAMPLE_W +: gcipsd_pkg::STAMP_W];
	assign chan_in  = s_tdata[gcipsd_pkg::SAMPLE_W + gcipsd_pkg::STAMP_W +: gcipsd_pkg::CHAN_W];

	// Classify the sample index against the windows
	assign gate_begin = gcipsd_pkg::INDEX_W'(start_q);
	assign short_end  = gate_begin + gcipsd_pkg::INDEX_W'(gate_short_q);
	assign long_end   = gate_begin + gcipsd_pkg::INDEX_W'(gate_long_q);
	assign first      = (idx_q == '0);
	assign in_base    = (idx_q < BASE_END);
	assign in_short   = (idx_q >= gate_begin) && (idx_q < short_end);
	assign in_long    = (idx_q >= gate_begin) && (idx_q < long_end);

	assign bsum_nx  = in_base  ? bsum_q + SUMW'(smp)  : bsum_q;
	assign ssum_nx  = in_short ? ssum_q + GSUMW'(smp) : ssum_q;
	assign lsum_nx  = in_long  ? lsum_q + GSUMW'(smp) : lsum_q;
	assign scnt_nx  = in_short ? scnt_q + gcipsd_pkg::COUNT_W'(1) : scnt_q;
	assign lcnt_nx  = in_long  ? lcnt_q + gcipsd_pkg::COUNT_W'(1) : lcnt_q;
	assign stamp_nx = first ? stamp_in : stamp_q;
	assign chan_nx  = first ? chan_in  : chan_q;

	assign s_tready = res_ready;
	assign take     = s_tvalid && s_tready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= gcipsd_pkg::START_RESET;
			gate_short_q <= gcipsd_pkg::GATE_SHORT_RESET;
			gate_long_q  <= gcipsd_pkg::GATE_LONG_RESET;
			pol_q        <= 1'b0;
		end else if (cfg_we) begin
			unique case (gcipsd_pkg::cfg_reg_t'(cfg_index))
				gcipsd_pkg::REG_INTEGRATION_START: begin
					start_q <= cfg_data[gcipsd_pkg::START_W-1:0];
				end
				gcipsd_pkg::REG_GATE_SHORT: begin
					gate_short_q <= cfg_data[gcipsd_pkg::COUNT_W-1:0];
				end
				gcipsd_pkg::REG_GATE_LONG: begin
					gate_long_q <= cfg_data[gcipsd_pkg::COUNT_W-1:0];
				end
				gcipsd_pkg::REG_POSITIVE_PULSE: begin
					pol_q <= cfg_data[0];
				end
			endcase
		end
	end

	// Accumulate each sample; clear on the last one of a waveform
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			bsum_q  <= '0;
			ssum_q  <= '0;
			lsum_q  <= '0;
			scnt_q  <= '0;
			lcnt_q  <= '0;
			stamp_q <= '0;
			chan_q  <= '0;
		end else if (take) begin
			stamp_q <= stamp_nx;
			chan_q  <= chan_nx;
			if (s_tlast) begin
				idx_q  <= '0;
				bsum_q <= '0;
				ssum_q <= '0;
				lsum_q <= '0;
				scnt_q <= '0;
				lcnt_q <= '0;
			end else begin
				if (idx_q != gcipsd_pkg::INDEX_MAX) idx_q <= idx_q + gcipsd_pkg::INDEX_W'(1);
				bsum_q <= bsum_nx;
				ssum_q <= ssum_nx;
				lsum_q <= lsum_nx;
				scnt_q <= scnt_nx;
				lcnt_q <= lcnt_nx;
			end
		end
	end

	// Per-waveform baseline and charge arithmetic
	gcipsd_charge_pipe #(
		.BASELINE_COUNT (BASELINE_COUNT),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_charge (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid && s_tlast),
		.in_ready    (res_ready),
		.in_stamp    (stamp_nx),
		.in_channel  (chan_nx),
		.in_pol      (pol_q),
		.in_bsum     (bsum_nx),
		.in_ssum     (ssum_nx),
		.in_scnt     (scnt_nx),
		.in_lsum     (lsum_nx),
		.in_lcnt     (lcnt_nx),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_stamp   (stamp_out),
		.out_channel (channel_out),
		.out_base    (baseline_fixed),
		.out_short   (charge_short),
		.out_long    (charge_long)
	);

	// Pack the result request
	assign m_tdata = {4'b0000, charge_long, charge_short, baseline_fixed, channel_out,
		stamp_out};

endmodule
